>>> src/mctt_pkg.sv
// mctt_pkg: shared types and constants of the tick timer bank
// bank size, action codes, command/result beats, timer store entry and request
// no dependencies
package mctt_pkg;

  localparam int unsigned NUM_TIMERS = 16;

  localparam int unsigned IdxW  = 4;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_TIMERS + 1);

  localparam logic [2:0] ACT_SET_PERIODIC = 3'd0;
  localparam logic [2:0] ACT_SET_ONCE     = 3'd1;
  localparam logic [2:0] ACT_STOP         = 3'd2;
  localparam logic [2:0] ACT_TICK         = 3'd3;
  localparam logic [2:0] ACT_TEST_CLEAR   = 3'd4;
  localparam logic [2:0] ACT_PEEK         = 3'd5;

  typedef struct packed {
    logic [2:0]       action;
    logic [IdxW-1:0]  timer_index;
    logic [DataW-1:0] start_count;
    logic [DataW-1:0] reload_interval;
  } cmd_t;

  typedef struct packed {
    logic            expired;
    logic [IdxW-1:0] echo_index;
  } res_t;

  typedef struct packed {
    logic             flag;
    logic [DataW-1:0] count;
    logic [DataW-1:0] reload;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [AddrW-1:0] raddr;
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

endpackage

>>> src/mctt_store.sv
// mctt_store: timer state memory, one write and one registered read port
// entries never written since reset read as zero through per-entry valid bits
// depends on mctt_pkg
module mctt_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mctt_pkg::mem_req_t  req_i,
  output mctt_pkg::entry_t    rd_o
);
  import mctt_pkg::*;

  entry_t                 mem_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  valid_q;
  entry_t                 rd_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rd_o = rd_valid_q ? rd_q : '0;

`ifndef SYNTH
  // no same-entry read and write in one cycle, so no forwarding is needed
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.re && req_i.we) |-> (req_i.raddr != req_i.waddr))
    else $error("read and write hit the same entry");
`endif

endmodule

>>> src/mctt_seq.sv
// mctt_seq: action sequencer with read-modify-write of the timer store
// single-entry actions and the tick walk over all entries, result register
// depends on mctt_pkg
module mctt_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mctt_pkg::cmd_t      cmd_i,
  output logic                res_valid_o,
  output mctt_pkg::res_t      res_o,
  output mctt_pkg::mem_req_t  req_o,
  input  mctt_pkg::entry_t    rd_i
);
  import mctt_pkg::*;

  localparam int unsigned ExtW = ((AddrW > IdxW) ? AddrW : IdxW) + 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ACCESS = 3'b010,
    ST_WALK   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;
  logic [2:0]        act_q, act_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic              ok_q, ok_d;

  logic              accept;
  logic [ExtW-1:0]   idx_ext;
  logic              ok_in;
  logic [AddrW-1:0]  addr_in;
  logic [CntW-1:0]   cnt_m1;
  entry_t            tick_e;

  assign accept  = start && !busy;
  assign idx_ext = ExtW'(cmd_i.timer_index);
  assign ok_in   = idx_ext < ExtW'(NUM_TIMERS);
  assign addr_in = idx_ext[AddrW-1:0];
  assign cnt_m1  = cnt_q - 1'b1;

  // one tick applied to the entry read in the previous cycle
  always_comb begin
    tick_e = rd_i;
    if (rd_i.count == DataW'(1)) begin
      tick_e.flag  = 1'b1;
      tick_e.count = rd_i.reload;
    end else if (rd_i.count != '0) begin
      tick_e.count = rd_i.count - 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    act_d       = act_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    ok_d        = ok_q;
    req_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d  = cmd_i.action;
          idx_d  = cmd_i.timer_index;
          addr_d = addr_in;
          ok_d   = ok_in;
          priority if (cmd_i.action == ACT_TICK) begin
            state_d = ST_WALK;
            cnt_d   = '0;
          end else if (cmd_i.action == ACT_TEST_CLEAR || cmd_i.action == ACT_PEEK) begin
            state_d     = ST_ACCESS;
            req_o.re    = ok_in;
            req_o.raddr = addr_in;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{expired: 1'b0, echo_index: cmd_i.timer_index};
            if (ok_in && (cmd_i.action == ACT_SET_PERIODIC ||
                          cmd_i.action == ACT_SET_ONCE || cmd_i.action == ACT_STOP)) begin
              req_o.we           = 1'b1;
              req_o.waddr        = addr_in;
              req_o.wdata.flag   = 1'b0;
              req_o.wdata.count  = (cmd_i.action == ACT_STOP) ? '0 : cmd_i.start_count;
              req_o.wdata.reload = (cmd_i.action == ACT_SET_PERIODIC) ?
                                   cmd_i.reload_interval : '0;
            end
          end
        end
      end
      ST_ACCESS: begin
        res_valid_d = 1'b1;
        res_d       = '{expired: ok_q & rd_i.flag, echo_index: idx_q};
        if (ok_q && act_q == ACT_TEST_CLEAR) begin
          req_o.we         = 1'b1;
          req_o.waddr      = addr_q;
          req_o.wdata      = rd_i;
          req_o.wdata.flag = 1'b0;
        end
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        // read entry cnt, write back entry cnt-1
        if (cnt_q < CntW'(NUM_TIMERS)) begin
          req_o.re    = 1'b1;
          req_o.raddr = cnt_q[AddrW-1:0];
        end
        if (cnt_q != '0) begin
          req_o.we    = 1'b1;
          req_o.waddr = cnt_m1[AddrW-1:0];
          req_o.wdata = tick_e;
        end
        if (cnt_q == CntW'(NUM_TIMERS)) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          res_d       = '{expired: 1'b0, echo_index: idx_q};
        end
        cnt_d = cnt_q + 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    act_q  <= act_d;
    idx_q  <= idx_d;
    addr_q <= addr_d;
    ok_q   <= ok_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && cnt_q == CntW'(NUM_TIMERS))
      |=> (res_valid_q && !res_q.expired && state_q == ST_IDLE))
    else $error("tick walk did not end with a result");

  a_access_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCESS) |=> (state_q == ST_IDLE && res_valid_q))
    else $error("flag access did not finish in one cycle");

  a_walk_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && cnt_q != CntW'(NUM_TIMERS)) |=> !res_valid_q)
    else $error("result beat during tick walk");

  a_access_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCESS && req_o.we) |-> (act_q == ACT_TEST_CLEAR))
    else $error("peek wrote the timer store");
`endif

endmodule

>>> src/multi_channel_tick_timer_bank_unit.sv
// channel  | ports                 | handshake
// command  | start, busy, cmd_i    | beat taken when start high and busy low
// result   | res_valid_o, res_o    | one-cycle strobe, receiver cannot stall
//
// set, stop and unused actions: result in the cycle after the beat, busy stays low
// test-and-clear and peek: at most one memory read, result registered from ST_ACCESS
// tick: busy during the ST_WALK pass over all entries, one store entry read and written per cycle
// reset is asynchronous active low; the store's valid bits clear at once
// multi_channel_tick_timer_bank_unit: top level, depends on mctt_pkg,
// mctt_store and mctt_seq
module multi_channel_tick_timer_bank_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  mctt_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  output mctt_pkg::res_t  res_o
);
  import mctt_pkg::*;

  mem_req_t  mem_req;
  entry_t    mem_rd;

  mctt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .req_o       (mem_req),
    .rd_i        (mem_rd)
  );

  mctt_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rd_o   (mem_rd)
  );

endmodule
